// File: rtl/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

    // Field widths of the stream items
    localparam int OPC_W    = 2;
    localparam int SID_W    = 4;
    localparam int VAL_W    = 32;
    localparam int STEP_W   = 14;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    // Table size and reporting limits
    localparam int DEFAULT_NUM_SLOTS = 16;
    localparam int RESULT_LIMIT      = 16;
    localparam int RPT_W             = $clog2(RESULT_LIMIT + 1);

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 14'd1000;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_TICK       = 2'd0;
    localparam logic [OPC_W-1:0] OP_REGISTER   = 2'd1;
    localparam logic [OPC_W-1:0] OP_UNREGISTER = 2'd2;
    localparam logic [OPC_W-1:0] OP_CLEAR      = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_REGISTER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNREGISTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // Input tdata layout, lowest field last
    typedef struct packed {
        logic [2:0]       pad;
        logic             start_enabled;
        logic [VAL_W-1:0] initial_count;
        logic [VAL_W-1:0] period_ms;
        logic [SID_W-1:0] slot_id;
    } in_data_t;

    // One slot entry in the table memory
    typedef struct packed {
        logic             enabled;
        logic [VAL_W-1:0] period;
        logic [VAL_W-1:0] count;
    } slot_word_t;

    // Outcome of one count update
    typedef struct packed {
        logic             fire;
        logic [VAL_W-1:0] new_count;
    } upd_t;

    // Result item handed to the output register
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SID_W-1:0]  slot;
        logic [STAT_W-1:0] status;
        logic              last;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/periodic_task_timer_table.sv
`default_nettype none

// Channel   Dir  Signals                          Contents
// s_*       in   s_tvalid/s_tready/s_tdata/s_tuser opcode, slot_id, period, count, enable
// m_*       out  m_tvalid/m_tready/m_tdata/m_tuser result_kind, slot, status, last
//                /m_tlast
// cfg_*     in   cfg_we/cfg_wdata                 tick_step
//
// Register scans the in-use bits for the lowest free slot, one slot per cycle.
// Tick sweeps the table one slot per cycle while the output does not stall,
// read-modify-write pipelined. A stalled output holds the item at work until
// its result is taken.
// Reset clears the in-use bits at once; no clearing pass. Input ready is low
// while an item is at work; the output register holds a result under stall.
module periodic_task_timer_table #(
    parameter int NUM_SLOTS = ptt_pkg::DEFAULT_NUM_SLOTS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ptt_pkg::IN_TDATA_W-1:0]  s_tdata,  // slot_id[3:0], period_ms[35:4],
                                                           // initial_count[67:36],
                                                           // start_enabled[68], zero
    input  wire logic [ptt_pkg::OPC_W-1:0]       s_tuser,  // opcode[1:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ptt_pkg::OUT_TDATA_W-1:0]      m_tdata,  // slot[3:0], status[5:4], zero
    output logic [ptt_pkg::KIND_W-1:0]           m_tuser,  // result_kind[1:0]
    output logic                                 m_tlast,  // last
    input  wire logic                            cfg_we,
    input  wire logic [ptt_pkg::STEP_W-1:0]      cfg_wdata // tick_step
);
    import ptt_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    // Control state
    logic [1:0]           state_reg,      state_next;
    logic [STEP_W-1:0]    tick_step_reg,  tick_step_next;
    logic [NUM_SLOTS-1:0] in_use_reg,     in_use_next;
    logic [SW-1:0]        scan_reg,       scan_next;
    logic [SW-1:0]        rd_idx_reg,     rd_idx_next;
    logic                 rd_active_reg,  rd_active_next;
    logic [SW-1:0]        ev_idx_reg,     ev_idx_next;
    logic                 ev_valid_reg,   ev_valid_next;
    logic [RPT_W-1:0]     n_reg,          n_next;
    logic                 pend_valid_reg, pend_valid_next;

    // Payload
    push_t                pend_reg,       pend_next;
    logic [VAL_W-1:0]     period_reg;
    logic [VAL_W-1:0]     init_reg;
    logic                 en_reg;

    in_data_t   in_d;
    logic       in_accept;
    logic [SW-1:0] sid_idx;
    logic       sid_ok;

    slot_word_t rd_word;
    slot_word_t wr_word;
    logic       ram_we;
    logic [SW-1:0] ram_waddr;
    logic       ram_re;

    upd_t       upd;
    logic       ev_live;
    logic       ev_report;
    logic       stall;

    logic       push_valid;
    logic       push_ready;
    push_t      push;

    assign in_d      = in_data_t'(s_tdata);
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign sid_idx   = SW'(in_d.slot_id);
    assign sid_ok    = (32'(in_d.slot_id) < NUM_SLOTS);

    // Slot table memory: enable, period, count
    ptt_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (NUM_SLOTS),
        .AW    (SW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_word),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (rd_word)
    );

    ptt_count_unit u_count (
        .word (rd_word),
        .step (tick_step_reg),
        .upd  (upd)
    );

    ptt_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push       (push),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // Evaluate stage of the tick sweep
    assign ev_live   = (state_reg == S_SWEEP) && ev_valid_reg
                       && in_use_reg[ev_idx_reg] && rd_word.enabled;
    assign ev_report = ev_live && upd.fire && (n_reg < RPT_W'(RESULT_LIMIT));
    assign stall     = ev_report && pend_valid_reg && !push_ready;

    // The pending result leaves when a newer one replaces it, or at the end
    assign push_valid = pend_valid_reg
                        && ((state_reg == S_FLUSH) || ((state_reg == S_SWEEP) && ev_report));
    always_comb
    begin
        push      = pend_reg;
        push.last = (state_reg == S_FLUSH);
    end

    assign tick_step_next = cfg_we ? cfg_wdata : tick_step_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        scan_next       = scan_reg;
        rd_idx_next     = rd_idx_reg;
        rd_active_next  = rd_active_reg;
        ev_idx_next     = ev_idx_reg;
        ev_valid_next   = ev_valid_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        ram_we          = 1'b0;
        ram_waddr       = ev_idx_reg;
        wr_word         = {rd_word.enabled, rd_word.period, upd.new_count};
        ram_re          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    pend_next.last = 1'b0;
                    unique case (s_tuser)
                        OP_TICK:
                        begin
                            rd_idx_next    = '0;
                            rd_active_next = 1'b1;
                            ev_valid_next  = 1'b0;
                            n_next         = '0;
                            state_next     = S_SWEEP;
                        end
                        OP_REGISTER:
                        begin
                            if (in_d.period_ms == '0)
                            begin
                                pend_valid_next  = 1'b1;
                                pend_next.kind   = KIND_REGISTER;
                                pend_next.slot   = '0;
                                pend_next.status = ST_INVALID;
                                state_next       = S_FLUSH;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = S_ALLOC;
                            end
                        end
                        OP_UNREGISTER:
                        begin
                            pend_valid_next = 1'b1;
                            pend_next.kind  = KIND_UNREGISTER;
                            pend_next.slot  = in_d.slot_id;
                            if (sid_ok && in_use_reg[sid_idx])
                            begin
                                in_use_next[sid_idx] = 1'b0;
                                pend_next.status     = ST_OK;
                            end
                            else
                            begin
                                pend_next.status = ST_INVALID;
                            end
                            state_next = S_FLUSH;
                        end
                        OP_CLEAR:
                        begin
                            in_use_next      = '0;
                            pend_valid_next  = 1'b1;
                            pend_next.kind   = KIND_CLEAR;
                            pend_next.slot   = '0;
                            pend_next.status = ST_OK;
                            state_next       = S_FLUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                // Scan for the lowest free slot
                pend_next.kind = KIND_REGISTER;
                pend_next.last = 1'b0;
                if (!in_use_reg[scan_reg])
                begin
                    in_use_next[scan_reg] = 1'b1;
                    ram_we           = 1'b1;
                    ram_waddr        = scan_reg;
                    wr_word          = {en_reg, period_reg, init_reg};
                    pend_valid_next  = 1'b1;
                    pend_next.slot   = SID_W'(scan_reg);
                    pend_next.status = ST_OK;
                    state_next       = S_FLUSH;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    pend_valid_next  = 1'b1;
                    pend_next.slot   = '0;
                    pend_next.status = ST_FULL;
                    state_next       = S_FLUSH;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_SWEEP:
            begin
                if (!rd_active_reg && !ev_valid_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (!stall)
                begin
                    // Write back the updated count
                    ram_we = ev_live;
                    if (ev_report)
                    begin
                        pend_valid_next  = 1'b1;
                        pend_next.kind   = KIND_FIRE;
                        pend_next.slot   = SID_W'(ev_idx_reg);
                        pend_next.status = ST_OK;
                        pend_next.last   = 1'b0;
                        n_next           = n_reg + 1'b1;
                    end
                    // Advance the read stage
                    ram_re        = rd_active_reg;
                    ev_valid_next = rd_active_reg;
                    ev_idx_next   = rd_idx_reg;
                    if (rd_active_reg)
                    begin
                        if (rd_idx_reg == LAST_IDX)
                        begin
                            rd_active_next = 1'b0;
                        end
                        else
                        begin
                            rd_idx_next = rd_idx_reg + 1'b1;
                        end
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (push_ready)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_step_reg  <= TICK_STEP_RESET;
            in_use_reg     <= '0;
            scan_reg       <= '0;
            rd_idx_reg     <= '0;
            rd_active_reg  <= 1'b0;
            ev_idx_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_step_reg  <= tick_step_next;
            in_use_reg     <= in_use_next;
            scan_reg       <= scan_next;
            rd_idx_reg     <= rd_idx_next;
            rd_active_reg  <= rd_active_next;
            ev_idx_reg     <= ev_idx_next;
            ev_valid_reg   <= ev_valid_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (in_accept)
        begin
            period_reg <= in_d.period_ms;
            init_reg   <= in_d.initial_count;
            en_reg     <= in_d.start_enabled;
        end
    end

`ifndef SYNTH
    // Sweep write-back never hits the entry being read
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != rd_idx_reg))
        else $error("table write and read hit the same slot");

    // A new item always starts with no result left over
    a_pend_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !pend_valid_reg)
        else $error("item accepted with a result still pending");

    // Replies are single items, so always marked last
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != KIND_FIRE)) |-> m_tlast)
        else $error("reply without last");

    // Fire results always carry status ok
    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_FIRE)) |-> (m_tdata[5:4] == ST_OK))
        else $error("fire result with bad status");
`endif

endmodule

`default_nettype wire

// File: rtl/ptt_ram.sv
`default_nettype none

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/ptt_count_unit.sv
`default_nettype none

module ptt_count_unit (
    input  wire ptt_pkg::slot_word_t       word,
    input  wire logic [ptt_pkg::STEP_W-1:0] step,
    output ptt_pkg::upd_t                  upd
);
    import ptt_pkg::*;

    logic [VAL_W:0]   sum;
    logic [VAL_W-1:0] sat;

    // Saturating add, then compare against the period
    always_comb
    begin
        sum           = {1'b0, word.count} + (VAL_W + 1)'(step);
        sat           = sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
        upd.fire      = (sat >= word.period);
        upd.new_count = upd.fire ? '0 : sat;
    end

endmodule

`default_nettype wire

// File: rtl/ptt_out_reg.sv
`default_nettype none

module ptt_out_reg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push_valid,
    input  wire ptt_pkg::push_t                  push,
    output logic                                 push_ready,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ptt_pkg::OUT_TDATA_W-1:0]      m_tdata,  // slot[3:0], status[5:4], zero
    output logic [ptt_pkg::KIND_W-1:0]           m_tuser,  // result_kind[1:0]
    output logic                                 m_tlast
);
    import ptt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    push_t item_reg;

    assign push_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_ready)
        begin
            valid_next = push_valid;
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            item_reg <= push;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - SID_W - STAT_W)'(0), item_reg.status, item_reg.slot};
    assign m_tuser  = item_reg.kind;
    assign m_tlast  = item_reg.last;

endmodule

`default_nettype wire

// File: tb/periodic_task_timer_table_tb.sv
module periodic_task_timer_table_tb;
    import ptt_pkg::*;

    localparam int NSLOT         = DEFAULT_NUM_SLOTS;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    // a tick with no fire keeps the input busy until its sweep of the table is done
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 78;
    localparam int NUM_PHASES    = 6;
    localparam int NUM_ROWS      = 19;

    // one row of the directed sequence
    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic [SID_W-1:0] sid;
        logic [VAL_W-1:0] period;
        logic [VAL_W-1:0] init;
        logic             en;
        logic             typed;
        push_t            want;
    } dir_row_t;

    localparam push_t NO_RESULT = '0;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [OPC_W-1:0]       s_tuser   = OP_TICK;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [STEP_W-1:0]      cfg_wdata = '0;

    // shadow of the slot table and the tick step
    logic              tbl_used   [NSLOT];
    logic              tbl_en     [NSLOT];
    logic [VAL_W-1:0]  tbl_period [NSLOT];
    logic [VAL_W-1:0]  tbl_count  [NSLOT];
    logic [STEP_W-1:0] step_cfg = TICK_STEP_RESET;

    push_t awaited[$];   // results still to come, oldest first
    push_t fresh[$];     // results of the item just predicted
    push_t head;

    int err_cnt   = 0;
    int cycle_cnt = 0;
    int ready_run = 0;
    bit quiet     = 1'b0;

    logic [STEP_W-1:0] phase_steps [NUM_PHASES] = '{14'd1, 14'd10000, 14'h3FFF, 14'd0,
                                                    14'd1, 14'd1000};

    periodic_task_timer_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    function automatic push_t mk_result(input logic [KIND_W-1:0] kind,
                                        input logic [SID_W-1:0] slot,
                                        input logic [STAT_W-1:0] status,
                                        input logic last);
        push_t r;
        r.kind   = kind;
        r.slot   = slot;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    // Work out the results of one item and update the shadow table
    function automatic void predict_table_op(input logic [OPC_W-1:0] op,
                                             input logic [SID_W-1:0] sid,
                                             input logic [VAL_W-1:0] per,
                                             input logic [VAL_W-1:0] init,
                                             input logic en);
        logic [VAL_W:0] sum;
        int             free_idx;
        fresh.delete();
        case (op)
            OP_REGISTER:
            begin
                free_idx = -1;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!tbl_used[i])
                        free_idx = i;
                if (per == '0)
                    fresh.push_back(mk_result(KIND_REGISTER, '0, ST_INVALID, 1'b1));
                else if (free_idx < 0)
                    fresh.push_back(mk_result(KIND_REGISTER, '0, ST_FULL, 1'b1));
                else
                begin
                    tbl_used[free_idx]   = 1'b1;
                    tbl_en[free_idx]     = en;
                    tbl_period[free_idx] = per;
                    tbl_count[free_idx]  = init;
                    fresh.push_back(mk_result(KIND_REGISTER, SID_W'(free_idx), ST_OK, 1'b1));
                end
            end
            OP_UNREGISTER:
            begin
                if (tbl_used[sid])
                begin
                    tbl_used[sid] = 1'b0;
                    fresh.push_back(mk_result(KIND_UNREGISTER, sid, ST_OK, 1'b1));
                end
                else
                    fresh.push_back(mk_result(KIND_UNREGISTER, sid, ST_INVALID, 1'b1));
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NSLOT; i++)
                    tbl_used[i] = 1'b0;
                fresh.push_back(mk_result(KIND_CLEAR, '0, ST_OK, 1'b1));
            end
            default:
            begin
                // tick: saturating add, fire and rewind at or past the period
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (tbl_used[i] && tbl_en[i])
                    begin
                        sum = {1'b0, tbl_count[i]} + step_cfg;
                        tbl_count[i] = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
                        if (tbl_count[i] >= tbl_period[i])
                        begin
                            tbl_count[i] = '0;
                            fresh.push_back(mk_result(KIND_FIRE, SID_W'(i), ST_OK, 1'b0));
                        end
                    end
                end
                if (fresh.size() != 0)
                    fresh[fresh.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // Hand one item over, then queue what it should produce
    task automatic send_item(input logic [OPC_W-1:0] op, input logic [SID_W-1:0] sid,
                             input logic [VAL_W-1:0] per, input logic [VAL_W-1:0] init,
                             input logic en, input logic typed, input push_t want);
        in_data_t pkt;
        int       gap;
        pkt               = '0;
        pkt.slot_id       = sid;
        pkt.period_ms     = per;
        pkt.initial_count = init;
        pkt.start_enabled = en;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 11);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pkt;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_table_op(op, sid, per, init, en);
        if (typed)
            awaited.push_back(want);
        else
            foreach (fresh[k])
                awaited.push_back(fresh[k]);
    endtask

    // Random item; even phases lean toward filling the table
    task automatic send_random_item(input int phase);
        logic [OPC_W-1:0] op;
        logic [SID_W-1:0] sid;
        logic [VAL_W-1:0] per;
        logic [VAL_W-1:0] init;
        logic             en;
        int               roll;
        int               span;
        int               start;
        bit               fill;
        fill = (phase % 2 == 0);
        roll = $urandom_range(0, 99);
        if (roll < (fill ? 25 : 45))
            op = OP_TICK;
        else if (roll < (fill ? 80 : 70))
            op = OP_REGISTER;
        else if (roll < 97)
            op = OP_UNREGISTER;
        else
            op = OP_CLEAR;
        span = (step_cfg == '0) ? 1000 : int'(step_cfg);
        case ($urandom_range(0, 9))
            0:          per = '0;
            1:          per = '1;
            2, 3, 4, 5: per = $urandom_range(1, 3 * span);
            6, 7:       per = $urandom_range(1, 1000000);
            default:    per = $urandom();
        endcase
        case ($urandom_range(0, 7))
            0:       init = '0;
            1:       init = '1;
            2:       init = '1 - $urandom_range(0, 3 * span);
            3, 4, 5: init = $urandom_range(0, 3 * span);
            default: init = $urandom();
        endcase
        en  = ($urandom_range(0, 4) != 0);
        sid = $urandom_range(0, NSLOT - 1);
        // most unregisters aim at a slot in use
        if (op == OP_UNREGISTER && $urandom_range(0, 2) != 0)
        begin
            start = sid;
            for (int k = NSLOT - 1; k >= 0; k--)
                if (tbl_used[(start + k) % NSLOT])
                    sid = SID_W'((start + k) % NSLOT);
        end
        send_item(op, sid, per, init, en, 1'b0, NO_RESULT);
    endtask

    // Stop sending and let every awaited result and the sweep finish
    task automatic settle_table();
        s_tvalid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_step(input logic [STEP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        step_cfg  = value;
    endtask

    // Output side: random stall bursts, none in the last phase
    always @(posedge clk)
    begin
        if (quiet)
            m_tready <= 1'b1;
        else if (ready_run != 0)
            ready_run <= ready_run - 1;
        else if ($urandom_range(0, 2) == 0)
        begin
            m_tready  <= 1'b0;
            ready_run <= $urandom_range(0, 10);
        end
        else
        begin
            m_tready  <= 1'b1;
            ready_run <= $urandom_range(0, 30);
        end
    end

    // Compare every result item with the oldest awaited one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d status %0d last %0d",
                       m_tuser, m_tdata[SID_W-1:0], m_tdata[SID_W+STAT_W-1:SID_W], m_tlast);
                err_cnt++;
            end
            else
            begin
                head = awaited.pop_front();
                check_field("result_kind", head.kind, m_tuser);
                check_field("slot", head.slot, m_tdata[SID_W-1:0]);
                check_field("status", head.status, m_tdata[SID_W+STAT_W-1:SID_W]);
                check_field("last", head.last, m_tlast);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("periodic_task_timer_table_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows [NUM_ROWS];

        // empty table, bad unregisters, zero period
        rows[0]  = '{OP_TICK, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, NO_RESULT};
        rows[1]  = '{OP_UNREGISTER, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1,
                     mk_result(KIND_UNREGISTER, 4'd0, ST_INVALID, 1'b1)};
        rows[2]  = '{OP_UNREGISTER, 4'd15, '1, '1, 1'b1, 1'b1,
                     mk_result(KIND_UNREGISTER, 4'd15, ST_INVALID, 1'b1)};
        rows[3]  = '{OP_REGISTER, 4'd0, 32'd0, '1, 1'b1, 1'b1,
                     mk_result(KIND_REGISTER, 4'd0, ST_INVALID, 1'b1)};
        rows[4]  = '{OP_REGISTER, 4'd0, 32'd1000, 32'd0, 1'b1, 1'b1,
                     mk_result(KIND_REGISTER, 4'd0, ST_OK, 1'b1)};
        rows[5]  = '{OP_TICK, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, NO_RESULT};
        // saturating count, disabled slot, count already past period
        rows[6]  = '{OP_REGISTER, 4'd7, '1, '1, 1'b1, 1'b1,
                     mk_result(KIND_REGISTER, 4'd1, ST_OK, 1'b1)};
        rows[7]  = '{OP_REGISTER, 4'd0, 32'd5000, 32'd0, 1'b0, 1'b1,
                     mk_result(KIND_REGISTER, 4'd2, ST_OK, 1'b1)};
        rows[8]  = '{OP_REGISTER, 4'd0, 32'd1, 32'hFFFF_FFFE, 1'b1, 1'b1,
                     mk_result(KIND_REGISTER, 4'd3, ST_OK, 1'b1)};
        rows[9]  = '{OP_TICK, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, NO_RESULT};
        rows[10] = '{OP_UNREGISTER, 4'd1, 32'd0, 32'd0, 1'b0, 1'b1,
                     mk_result(KIND_UNREGISTER, 4'd1, ST_OK, 1'b1)};
        rows[11] = '{OP_REGISTER, 4'd0, 32'd2000, 32'd5000, 1'b1, 1'b1,
                     mk_result(KIND_REGISTER, 4'd1, ST_OK, 1'b1)};
        rows[12] = '{OP_TICK, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, NO_RESULT};
        rows[13] = '{OP_UNREGISTER, 4'd2, 32'd0, 32'd0, 1'b0, 1'b1,
                     mk_result(KIND_UNREGISTER, 4'd2, ST_OK, 1'b1)};
        // clear, then the table starts over
        rows[14] = '{OP_CLEAR, 4'd9, '1, '1, 1'b1, 1'b1,
                     mk_result(KIND_CLEAR, 4'd0, ST_OK, 1'b1)};
        rows[15] = '{OP_UNREGISTER, 4'd3, 32'd0, 32'd0, 1'b0, 1'b1,
                     mk_result(KIND_UNREGISTER, 4'd3, ST_INVALID, 1'b1)};
        rows[16] = '{OP_TICK, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, NO_RESULT};
        rows[17] = '{OP_REGISTER, 4'd15, 32'd1, 32'd0, 1'b0, 1'b1,
                     mk_result(KIND_REGISTER, 4'd0, ST_OK, 1'b1)};
        rows[18] = '{OP_UNREGISTER, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1,
                     mk_result(KIND_UNREGISTER, 4'd0, ST_OK, 1'b1)};

        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_used[i]   = 1'b0;
            tbl_en[i]     = 1'b0;
            tbl_period[i] = '0;
            tbl_count[i]  = '0;
        end
        phase_steps[4] = STEP_W'($urandom_range(1, 10000));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
            send_item(rows[r].op, rows[r].sid, rows[r].period, rows[r].init,
                      rows[r].en, rows[r].typed, rows[r].want);

        // random phases, each at its own tick step; the table carries over
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle_table();
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            write_tick_step(phase_steps[p]);
            repeat (PHASE_ITEMS) send_random_item(p);
        end

        settle_table();
        if (err_cnt == 0)
            $display("periodic_task_timer_table_tb OK");
        else
            $display("periodic_task_timer_table_tb NOT OK");
        $finish;
    end

endmodule

// File: periodic_task_timer_table.f
rtl/ptt_pkg.sv
rtl/ptt_ram.sv
rtl/ptt_count_unit.sv
rtl/ptt_out_reg.sv
rtl/periodic_task_timer_table.sv
tb/periodic_task_timer_table_tb.sv
